// ===== rtl/core/pngse_pkg.sv =====
package pngse_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_end;
  } png_byte_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // big-endian byte i of a word
  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] i);
    return v[8*(3-i) +: 8];
  endfunction

endpackage

// ===== rtl/core/pngse_len.sv =====
module pngse_len #(
  parameter int unsigned WW = 15,
  parameter int unsigned HW = 15,
  parameter int unsigned RW = 32
) (
  input  logic          clk_i,
  input  logic          start_i,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  output logic [RW-1:0] raw_o,
  output logic [31:0]   plen_o
);
  // raw = h*(4w+1); blocks = ceil(raw/65535) by folding 16-bit digits
  logic [RW-1:0] raw_q, x_q, q_q;
  logic [RW-1:0] hi, lo, blocks;
  logic [WW+1:0] w4;

  assign w4     = {width_i, 2'b01};
  assign hi     = x_q >> 16;
  assign lo     = x_q & RW'(65535);
  assign blocks = q_q + RW'(x_q != '0);
  assign raw_o  = raw_q;
  assign plen_o = 32'(64'(blocks) * 64'd5 + 64'(raw_q) + 64'd6);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      raw_q <= RW'(height_i) * RW'(w4);
      x_q   <= RW'(height_i) * RW'(w4);
      q_q   <= '0;
    end else begin
      q_q <= q_q + hi;
      x_q <= hi + lo;
    end
  end
endmodule

// ===== rtl/core/png_stored_stream_encoder_top.sv =====
// Streaming PNG writer: RGBA pixels in row-major order go in, the bytes of an
// uncompressed PNG (signature, IHDR, one IDAT of stored deflate blocks, IEND)
// come out of the output byte register one per cycle while a pixel is held and
// out_stall_i is low. Width and height are latched at an image's first pixel.
// A pixel yields 4 bytes (5 at a row start) plus 5 at each 65535-byte block
// boundary; the first pixel adds 43 header bytes, the last 20 trailer bytes.
// A 1x1 image sends its trailer on the next transfer, whose data is ignored.
module png_stored_stream_encoder_top #(
  parameter int unsigned MAX_WIDTH  = 16384,
  parameter int unsigned MAX_HEIGHT = 16384
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pngse_pkg::pixel_t          in_pixel_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pngse_pkg::png_byte_t       out_pkt_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pngse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [14:0]                cfg_data_i
);
  import pngse_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = WW + HW + 2;

  typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_RAW, PH_TRL} phase_e;

  phase_e        phase_q, phase_d, eph;
  logic [5:0]    cnt_q, cnt_d, ecnt;
  logic [2:0]    rb_q, rb_d, erb;
  logic [2:0]    hi_q, hi_d, ehi;
  logic          first_q, first_d, active_q, active_d, pend_q, pend_d;
  logic [WW-1:0] lat_w_q, lat_w_d, col_q, col_d, col_n;
  logic [HW-1:0] lat_h_q, lat_h_d, row_q, row_d, row_n;
  logic [15:0]   blk_q, blk_d, adl_q, adl_d, adh_q, adh_d, blen, binv;
  logic [RW-1:0] rawl_q, rawl_d, raw_len;
  logic [31:0]   crc_q, crc_d, crc_in, plen, cw, ch;
  logic [16:0]   asum, hsum;
  logic [14:0]   cfg_w_q, cfg_h_q;
  pixel_t        buf_q;
  logic          buf_v_q, out_v_q;
  png_byte_t     out_q;
  logic          adv, done, need_hdr, crc_upd, crc_init, len_start, run_last, f_end;
  logic [7:0]    byte_v, raw_b;

  pngse_len #(.WW(WW), .HW(HW), .RW(RW)) u_len (
    .clk_i    (clk_i),
    .start_i  (len_start),
    .width_i  (lat_w_q),
    .height_i (lat_h_q),
    .raw_o    (raw_len),
    .plen_o   (plen)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_pkt_o   = out_q;
  assign adv         = buf_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o  = buf_v_q && !(adv && done);

  assign eph  = (phase_q != PH_IDLE) ? phase_q :
                pend_q ? PH_TRL : active_q ? PH_RAW : PH_HDR;
  assign ecnt = (phase_q == PH_IDLE) ? 6'd0 : cnt_q;
  assign erb  = (phase_q == PH_IDLE) ? ((col_q == '0) ? 3'd0 : 3'd1) : rb_q;
  assign ehi  = (phase_q == PH_IDLE) ? 3'd0 : hi_q;

  assign need_hdr = (blk_q == '0) && (rawl_q != '0);
  assign blen     = (64'(rawl_q) > 64'(BLOCK_MAX)) ? BLOCK_MAX : 16'(rawl_q);
  assign binv     = ~blen;
  assign cw       = 32'(cfg_w_q);
  assign ch       = 32'(cfg_h_q);
  assign col_n    = col_q + WW'(1);

  always_comb begin
    case (erb)
      3'd1:    raw_b = buf_q.red;
      3'd2:    raw_b = buf_q.green;
      3'd3:    raw_b = buf_q.blue;
      3'd4:    raw_b = buf_q.alpha;
      default: raw_b = 8'd0;
    endcase
  end

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; rb_d = rb_q; hi_d = hi_q;
    first_d = first_q; active_d = active_q; pend_d = pend_q;
    lat_w_d = lat_w_q; lat_h_d = lat_h_q; col_d = col_q; row_d = row_q;
    blk_d = blk_q; rawl_d = rawl_q; adl_d = adl_q; adh_d = adh_q;
    byte_v = 8'd0; crc_upd = 1'b0; crc_init = 1'b0; len_start = 1'b0;
    done = 1'b0; run_last = 1'b0; f_end = 1'b0;
    asum = '0; hsum = '0; row_n = row_q;
    if (adv) begin
      case (eph)
        PH_HDR: begin
          case (ecnt)
            6'd0:  byte_v = 8'h89;
            6'd1:  byte_v = 8'h50;
            6'd2:  byte_v = 8'h4E;
            6'd3:  byte_v = 8'h47;
            6'd4:  byte_v = 8'h0D;
            6'd5:  byte_v = 8'h0A;
            6'd6:  byte_v = 8'h1A;
            6'd7:  byte_v = 8'h0A;
            6'd11: byte_v = 8'd13;
            6'd12: byte_v = 8'h49;
            6'd13: byte_v = 8'h48;
            6'd14: byte_v = 8'h44;
            6'd15: byte_v = 8'h52;
            6'd16, 6'd17, 6'd18, 6'd19: byte_v = be_byte(32'(lat_w_q), ecnt[1:0]);
            6'd20, 6'd21, 6'd22, 6'd23: byte_v = be_byte(32'(lat_h_q), ecnt[1:0]);
            6'd24: byte_v = 8'd8;
            6'd25: byte_v = 8'd6;
            6'd29, 6'd30, 6'd31, 6'd32: byte_v = be_byte(~crc_q, 2'(ecnt - 6'd29));
            6'd33, 6'd34, 6'd35, 6'd36: byte_v = be_byte(plen, 2'(ecnt - 6'd33));
            6'd37: byte_v = 8'h49;
            6'd38: byte_v = 8'h44;
            6'd39: byte_v = 8'h41;
            6'd40: byte_v = 8'h54;
            6'd41: byte_v = 8'h78;
            6'd42: byte_v = 8'h01;
            default: byte_v = 8'd0;
          endcase
          crc_init = (ecnt == 6'd12) || (ecnt == 6'd37);
          crc_upd  = ((ecnt >= 6'd12) && (ecnt <= 6'd28)) || (ecnt >= 6'd37);
          if (ecnt == 6'd0) begin
            lat_w_d = (cw == 32'd0) ? WW'(1) :
                      (cw > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cw);
            lat_h_d = (ch == 32'd0) ? HW'(1) :
                      (ch > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(ch);
            col_d = '0; row_d = '0; blk_d = '0; adl_d = 16'd1; adh_d = '0;
            first_d = 1'b1;
          end
          if (ecnt == 6'd1) len_start = 1'b1;
          if (ecnt == 6'd2) rawl_d = raw_len;
          if (ecnt == 6'd42) begin
            phase_d = PH_RAW; cnt_d = '0; rb_d = 3'd0; hi_d = '0; active_d = 1'b1;
          end else begin
            phase_d = PH_HDR; cnt_d = ecnt + 6'd1;
          end
        end
        PH_RAW: begin
          phase_d = PH_RAW;
          rb_d    = erb;
          crc_upd = 1'b1;
          if (need_hdr) begin
            case (ehi)
              3'd0:    byte_v = {7'd0, (64'(rawl_q) <= 64'(BLOCK_MAX))};
              3'd1:    byte_v = blen[7:0];
              3'd2:    byte_v = blen[15:8];
              3'd3:    byte_v = binv[7:0];
              default: byte_v = binv[15:8];
            endcase
            if (ehi == 3'd4) begin
              blk_d = blen; hi_d = '0;
            end else begin
              hi_d = ehi + 3'd1;
            end
          end else begin
            byte_v = raw_b;
            hi_d   = '0;
            asum   = {1'b0, adl_q} + {9'd0, raw_b};
            if (asum >= ADLER_MOD) asum = asum - ADLER_MOD;
            adl_d  = asum[15:0];
            hsum   = {1'b0, adh_q} + asum;
            if (hsum >= ADLER_MOD) hsum = hsum - ADLER_MOD;
            adh_d  = hsum[15:0];
            if (blk_q != '0) blk_d = blk_q - 16'd1;
            if (rawl_q != '0) rawl_d = rawl_q - RW'(1);
            if (erb == 3'd4) begin
              if (col_n >= lat_w_q) begin
                col_d = '0;
                row_n = row_q + HW'(1);
              end else begin
                col_d = col_n;
              end
              row_d = row_n;
              if (row_n >= lat_h_q) begin
                if (first_q) begin
                  pend_d = 1'b1; phase_d = PH_IDLE; done = 1'b1; run_last = 1'b1;
                end else begin
                  phase_d = PH_TRL; cnt_d = '0;
                end
              end else begin
                phase_d = PH_IDLE; done = 1'b1; run_last = 1'b1;
              end
            end else begin
              rb_d = erb + 3'd1;
            end
          end
        end
        PH_TRL: begin
          case (ecnt[4:2])
            3'd0:    byte_v = be_byte({adh_q, adl_q}, ecnt[1:0]);
            3'd1:    byte_v = be_byte(~crc_q, ecnt[1:0]);
            3'd3: begin
              case (ecnt[1:0])
                2'd0:    byte_v = 8'h49;
                2'd1:    byte_v = 8'h45;
                2'd2:    byte_v = 8'h4E;
                default: byte_v = 8'h44;
              endcase
            end
            3'd4:    byte_v = be_byte(~crc_q, ecnt[1:0]);
            default: byte_v = 8'd0;
          endcase
          crc_upd  = (ecnt <= 6'd3) || ((ecnt >= 6'd12) && (ecnt <= 6'd15));
          crc_init = (ecnt == 6'd12);
          if (ecnt == 6'd19) begin
            f_end = 1'b1; run_last = 1'b1; done = 1'b1;
            phase_d = PH_IDLE; col_d = '0; row_d = '0; blk_d = '0; rawl_d = '0;
            adl_d = 16'd1; adh_d = '0; active_d = 1'b0; pend_d = 1'b0;
          end else begin
            phase_d = PH_TRL; cnt_d = ecnt + 6'd1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      if (done) first_d = 1'b0;
    end
  end

  assign crc_in = crc_init ? ALL_ONES : crc_q;
  always_comb begin
    crc_d = crc_q;
    if (adv && crc_upd) crc_d = crc_byte(crc_in, byte_v);
    if (adv && f_end)   crc_d = ALL_ONES;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; cnt_q <= '0; rb_q <= '0; hi_q <= '0;
      first_q <= 1'b0; active_q <= 1'b0; pend_q <= 1'b0;
      lat_w_q <= WW'(1); lat_h_q <= HW'(1); col_q <= '0; row_q <= '0;
      blk_q <= '0; rawl_q <= '0; adl_q <= 16'd1; adh_q <= '0; crc_q <= ALL_ONES;
      cfg_w_q <= 15'd1; cfg_h_q <= 15'd1;
      buf_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; rb_q <= rb_d; hi_q <= hi_d;
      first_q <= first_d; active_q <= active_d; pend_q <= pend_d;
      lat_w_q <= lat_w_d; lat_h_q <= lat_h_d; col_q <= col_d; row_q <= row_d;
      blk_q <= blk_d; rawl_q <= rawl_d; adl_q <= adl_d; adh_q <= adh_d; crc_q <= crc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_WIDTH)  cfg_w_q <= cfg_data_i;
        if (cfg_index_i == REG_HEIGHT) cfg_h_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        buf_v_q <= 1'b1;
      end else if (adv && done) begin
        buf_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) buf_q <= in_pixel_i;
    if (adv) begin
      out_q.out_byte <= byte_v;
      out_q.run_last <= run_last;
      out_q.file_end <= f_end;
    end
  end
endmodule
